// ===== hw/rtl/ctsr_pkg.sv =====
// ----------------------------------------------------------------------------
// ctsr_pkg
// Shared types and codes for the CAN transport segment reassembler.
// ----------------------------------------------------------------------------
package ctsr_pkg;

   // Sizes
   localparam int BUFFER_BYTES_DEF = 512;
   localparam int BYTE_W           = 8;
   localparam int LEN_W            = 10;
   localparam int CSR_IDX_W        = 2;
   localparam int ID_W             = 11;

   // Register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_START_ID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_ID   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_ID  = 2'd2;

   // Identifier reset values
   localparam logic [ID_W-1:0] START_ID_RST = 11'd256;
   localparam logic [ID_W-1:0] END_ID_RST   = 11'd257;
   localparam logic [ID_W-1:0] DATA_ID_RST  = 11'd258;

   // Result codes
   localparam logic [2:0] RC_OK            = 3'd0;
   localparam logic [2:0] RC_NOT_RECEIVING = 3'd1;
   localparam logic [2:0] RC_SEQ_ERR       = 3'd2;
   localparam logic [2:0] RC_MALFORMED     = 3'd3;
   localparam logic [2:0] RC_BAD_LENGTH    = 3'd4;
   localparam logic [2:0] RC_PENDING       = 3'd5;

   // Message kinds
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_END   = 2'd1;
   localparam logic [1:0] KIND_DATA  = 2'd2;

   // Frame markers and protocol control nibbles
   localparam logic [7:0] START_MARK  = 8'hEE;
   localparam logic [7:0] END_MARK    = 8'hFF;
   localparam logic [3:0] PCI_SINGLE  = 4'd0;
   localparam logic [3:0] PCI_FIRST   = 4'd1;
   localparam logic [3:0] PCI_CONSEC  = 4'd2;

   // Byte counts
   localparam logic [2:0] FF_STORE_BYTES = 3'd6;
   localparam logic [2:0] CF_MAX_BYTES   = 3'd7;
   localparam logic [2:0] FF_FIRST_BYTE  = 3'd2;
   localparam logic [2:0] CF_FIRST_BYTE  = 3'd1;
   localparam logic [3:0] MIN_HDR_DLC    = 4'd5;
   localparam logic [3:0] MAX_DLC        = 4'd8;
   localparam logic [LEN_W-1:0] SEQ_BYTES = 10'd2;

   typedef struct packed {
      logic [ID_W-1:0] start_fid;
      logic [ID_W-1:0] end_id;
      logic [ID_W-1:0] data_id;
   } ids_type;

   typedef struct packed {
      logic            is_standard_id;
      logic            is_data_frame;
      logic [ID_W-1:0] frame_id;
      logic [3:0]      length_code;
      logic [7:0][7:0] data;
   } frm_type;

   typedef struct packed {
      logic             receiving;
      logic [3:0]       next_sn;
      logic [LEN_W-1:0] total;
      logic [LEN_W-1:0] copied;
   } st_type;

   typedef struct packed {
      logic [2:0]  code;
      logic        valid;
      logic [1:0]  kind;
      logic [31:0] header;
      logic [15:0] seq;
      logic [8:0]  plen;
      logic [63:0] chunk;
   } item_type;

   typedef struct packed {
      logic             store;
      item_type         item;
      st_type           nxt;
      logic [LEN_W-1:0] wr_base;
      logic [2:0]       wr_first;
      logic [2:0]       wr_count;
      logic             wr_emit;
   } dec_type;

endpackage

// ===== hw/rtl/ctsr_ram.sv =====
// ----------------------------------------------------------------------------
// ctsr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ctsr_ram #(
   parameter int WIDTH = ctsr_pkg::BYTE_W,
   parameter int DEPTH = ctsr_pkg::BUFFER_BYTES_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ctsr_decode.sv =====
// ----------------------------------------------------------------------------
// ctsr_decode
// Classifies one latched frame against the transfer state and decides the
// status, the immediate result, the buffer writes and the next state.
// ----------------------------------------------------------------------------
module ctsr_decode #(
   parameter int BUFFER_BYTES = ctsr_pkg::BUFFER_BYTES_DEF
) (
   input  ctsr_pkg::frm_type frm,
   input  ctsr_pkg::st_type  st,
   input  ctsr_pkg::ids_type ids,
   output ctsr_pkg::dec_type dec
);
   import ctsr_pkg::*;

   localparam logic [11:0] BUF_LIMIT = 12'(BUFFER_BYTES);

   logic             fmt_ok;
   logic             is_start;
   logic             is_end;
   logic [3:0]       pci;
   logic [3:0]       low_nib;
   logic [2:0]       sf_plen;
   logic [11:0]      ff_len;
   logic [LEN_W-1:0] remaining;
   logic [2:0]       need;
   logic [LEN_W:0]   fill_sum;
   logic             cf_short;

   assign fmt_ok    = frm.is_standard_id && frm.is_data_frame &&
                      (frm.length_code != 4'd0) && (frm.length_code <= MAX_DLC);
   assign is_start  = (frm.frame_id == ids.start_fid);
   assign is_end    = (frm.frame_id == ids.end_id);
   assign pci       = frm.data[0][7:4];
   assign low_nib   = frm.data[0][3:0];
   assign sf_plen   = low_nib[2:0] - 3'd2;
   assign ff_len    = {low_nib, frm.data[1]};
   assign remaining = (st.total > st.copied) ? (st.total - st.copied) : '0;
   assign need      = (remaining > LEN_W'(CF_MAX_BYTES)) ? CF_MAX_BYTES : remaining[2:0];
   assign fill_sum  = {1'b0, st.copied} + {{(LEN_W - 2){1'b0}}, need};
   assign cf_short  = (frm.length_code < 4'd2) || (frm.length_code <= {1'b0, need});

   always_comb begin
      dec           = '0;
      dec.nxt       = st;
      dec.item.code = RC_MALFORMED;
      if (!fmt_ok) begin
         dec.item.code = RC_MALFORMED;
      end else if (is_start || is_end) begin
         // Start or end frame: with a good marker and length, deliver the header word and drop any transfer
         if ((frm.length_code >= MIN_HDR_DLC) &&
             (frm.data[0] == (is_start ? START_MARK : END_MARK))) begin
            dec.nxt.receiving = 1'b0;
            dec.nxt.copied    = '0;
            dec.item.code     = RC_OK;
            dec.item.valid    = 1'b1;
            dec.item.kind     = is_start ? KIND_START : KIND_END;
            dec.item.header   = {frm.data[1], frm.data[2], frm.data[3], frm.data[4]};
         end
      end else if (frm.frame_id != ids.data_id) begin
         dec.item.code = RC_MALFORMED;
      end else begin
         case (pci)
            PCI_SINGLE: begin
               if ((low_nib >= 4'd3) && (low_nib <= 4'd7) &&
                   ({1'b0, frm.length_code} >= ({1'b0, low_nib} + 5'd1))) begin
                  dec.nxt.total     = {{(LEN_W - 4){1'b0}}, low_nib};
                  dec.nxt.receiving = 1'b0;
                  dec.nxt.copied    = '0;
                  dec.item.code     = RC_OK;
                  dec.item.valid    = 1'b1;
                  dec.item.kind     = KIND_DATA;
                  dec.item.seq      = {frm.data[1], frm.data[2]};
                  dec.item.plen     = {6'd0, sf_plen};
                  for (int b = 0; b < 5; b++) begin
                     if (3'(b) < sf_plen) begin
                        dec.item.chunk[8*b +: 8] = frm.data[3+b];
                     end
                  end
               end
            end
            PCI_FIRST: begin
               dec.nxt.receiving = 1'b0;
               dec.nxt.copied    = '0;
               if (frm.length_code != MAX_DLC) begin
                  dec.item.code = RC_MALFORMED;
               end else if ((ff_len > BUF_LIMIT) || (ff_len <= 12'd6)) begin
                  dec.nxt.total = '0;
                  dec.item.code = RC_BAD_LENGTH;
               end else begin
                  // Open the transfer and store the first six bytes
                  dec.nxt.total     = ff_len[LEN_W-1:0];
                  dec.nxt.receiving = 1'b1;
                  dec.nxt.next_sn   = 4'd1;
                  dec.nxt.copied    = {{(LEN_W - 3){1'b0}}, FF_STORE_BYTES};
                  dec.store         = 1'b1;
                  dec.wr_base       = '0;
                  dec.wr_first      = FF_FIRST_BYTE;
                  dec.wr_count      = FF_STORE_BYTES;
                  dec.item.code     = RC_OK;
               end
            end
            PCI_CONSEC: begin
               if (!st.receiving) begin
                  dec.item.code = RC_NOT_RECEIVING;
               end else if (cf_short) begin
                  dec.nxt.receiving = 1'b0;
                  dec.nxt.copied    = '0;
                  dec.item.code     = RC_MALFORMED;
               end else if (low_nib != st.next_sn) begin
                  dec.nxt.receiving = 1'b0;
                  dec.nxt.copied    = '0;
                  dec.item.code     = RC_SEQ_ERR;
               end else begin
                  // Append up to seven bytes, deliver if the message is full
                  dec.nxt.next_sn = st.next_sn + 4'd1;
                  dec.store       = 1'b1;
                  dec.wr_base     = st.copied;
                  dec.wr_first    = CF_FIRST_BYTE;
                  dec.wr_count    = need;
                  if (fill_sum >= {1'b0, st.total}) begin
                     dec.nxt.receiving = 1'b0;
                     dec.nxt.copied    = '0;
                     dec.wr_emit       = 1'b1;
                     dec.item.code     = RC_OK;
                     dec.item.valid    = 1'b1;
                     dec.item.kind     = KIND_DATA;
                     dec.item.plen     = 9'(st.total - SEQ_BYTES);
                  end else begin
                     dec.nxt.copied = fill_sum[LEN_W-1:0];
                     dec.item.code  = RC_PENDING;
                  end
               end
            end
            default: begin
               dec.item.code = RC_PENDING;
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/ctsr_seq.sv =====
// ----------------------------------------------------------------------------
// ctsr_seq
// Request sequencer: latches a frame, applies the decision, writes frame
// bytes to the buffer one a cycle and reads the message back into chunks.
// ----------------------------------------------------------------------------
module ctsr_seq #(
   parameter int BUFFER_BYTES = ctsr_pkg::BUFFER_BYTES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  ctsr_pkg::frm_type               req_frame,
   output ctsr_pkg::frm_type               frm,
   output ctsr_pkg::st_type                st,
   input  ctsr_pkg::dec_type               dec,
   output logic                            ram_wr_en,
   output logic [$clog2(BUFFER_BYTES)-1:0] ram_wr_addr,
   output logic [7:0]                      ram_wr_data,
   output logic                            ram_rd_en,
   output logic [$clog2(BUFFER_BYTES)-1:0] ram_rd_addr,
   input  logic [7:0]                      ram_rd_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output ctsr_pkg::item_type              rsp_item,
   output logic                            rsp_last
);
   import ctsr_pkg::*;

   localparam int ADDR_W = $clog2(BUFFER_BYTES);

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_DECODE    = 4'd1;
   localparam logic [3:0] S_WRITE     = 4'd2;
   localparam logic [3:0] S_SEQ_HI    = 4'd3;
   localparam logic [3:0] S_SEQ_LO    = 4'd4;
   localparam logic [3:0] S_SEQ_CAP   = 4'd5;
   localparam logic [3:0] S_CHUNK     = 4'd6;
   localparam logic [3:0] S_CHUNK_END = 4'd7;
   localparam logic [3:0] S_OUT       = 4'd8;

   logic [3:0]       state_ff, state_in;
   frm_type          frm_ff, frm_in;
   st_type           st_ff, st_in;
   logic [LEN_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [2:0]       wr_src_ff, wr_src_in;
   logic [2:0]       wr_left_ff, wr_left_in;
   logic             wr_emit_ff, wr_emit_in;
   logic [8:0]       pos_ff, pos_in;
   logic [2:0]       lane_ff, lane_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [2:0]       rd_lane_ff, rd_lane_in;
   logic             rsp_valid_ff, rsp_valid_in;
   item_type         rsp_item_ff, rsp_item_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_fire;
   logic             rsp_fire;
   logic             out_free;
   logic [LEN_W-1:0] rd_idx;

   assign req_ready = (state_ff == S_IDLE) || ((state_ff == S_OUT) && rsp_last_ff);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rd_idx    = {1'b0, pos_ff} + SEQ_BYTES;

   assign frm         = frm_ff;
   assign st          = st_ff;
   assign ram_wr_addr = wr_ptr_ff[ADDR_W-1:0];
   assign ram_wr_data = frm_ff.data[wr_src_ff];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_item    = rsp_item_ff;
   assign rsp_last    = rsp_last_ff;

   always_comb begin
      state_in     = state_ff;
      frm_in       = frm_ff;
      st_in        = st_ff;
      wr_ptr_in    = wr_ptr_ff;
      wr_src_in    = wr_src_ff;
      wr_left_in   = wr_left_ff;
      wr_emit_in   = wr_emit_ff;
      pos_in       = pos_ff;
      lane_in      = lane_ff;
      rd_pend_in   = 1'b0;
      rd_lane_in   = lane_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      // Drop the byte read last cycle into its chunk lane
      if (rd_pend_ff) begin
         rsp_item_in.chunk[{rd_lane_ff, 3'b000} +: 8] = ram_rd_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               frm_in   = req_frame;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            // Hold until the result register is free
            if (out_free) begin
               st_in       = dec.nxt;
               rsp_item_in = dec.item;
               if (dec.store) begin
                  wr_ptr_in  = dec.wr_base;
                  wr_src_in  = dec.wr_first;
                  wr_left_in = dec.wr_count;
                  wr_emit_in = dec.wr_emit;
                  state_in   = S_WRITE;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  state_in     = S_OUT;
               end
            end
         end
         S_WRITE: begin
            ram_wr_en = (wr_left_ff != 3'd0);
            wr_ptr_in = wr_ptr_ff + LEN_W'(1);
            wr_src_in = wr_src_ff + 3'd1;
            if (wr_left_ff != 3'd0) begin
               wr_left_in = wr_left_ff - 3'd1;
            end
            if (wr_left_ff <= 3'd1) begin
               if (wr_emit_ff) begin
                  state_in = S_SEQ_HI;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_last_in  = 1'b1;
                  state_in     = S_OUT;
               end
            end
         end
         S_SEQ_HI: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = '0;
            state_in    = S_SEQ_LO;
         end
         S_SEQ_LO: begin
            ram_rd_en              = 1'b1;
            ram_rd_addr            = ADDR_W'(1);
            rsp_item_in.seq[15:8]  = ram_rd_data;
            state_in               = S_SEQ_CAP;
         end
         S_SEQ_CAP: begin
            rsp_item_in.seq[7:0] = ram_rd_data;
            pos_in               = '0;
            lane_in              = '0;
            state_in             = S_CHUNK;
         end
         S_CHUNK: begin
            // Issue one payload byte read per cycle
            ram_rd_en   = 1'b1;
            ram_rd_addr = rd_idx[ADDR_W-1:0];
            rd_pend_in  = 1'b1;
            rd_lane_in  = lane_ff;
            pos_in      = pos_ff + 9'd1;
            lane_in     = lane_ff + 3'd1;
            if ((lane_ff == 3'd7) || ((pos_ff + 9'd1) == rsp_item_ff.plen)) begin
               state_in = S_CHUNK_END;
            end
         end
         S_CHUNK_END: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = (pos_ff == rsp_item_ff.plen);
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (req_fire) begin
               frm_in   = req_frame;
               state_in = S_DECODE;
            end else if (rsp_fire) begin
               if (rsp_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  rsp_item_in.chunk = '0;
                  lane_in           = '0;
                  state_in          = S_CHUNK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         st_ff        <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         st_ff        <= st_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and pointers
   always_ff @(posedge clock) begin
      frm_ff      <= frm_in;
      wr_ptr_ff   <= wr_ptr_in;
      wr_src_ff   <= wr_src_in;
      wr_left_ff  <= wr_left_in;
      wr_emit_ff  <= wr_emit_in;
      pos_ff      <= pos_in;
      lane_ff     <= lane_in;
      rd_lane_ff  <= rd_lane_in;
      rsp_item_ff <= rsp_item_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

// ===== hw/rtl/can_tp_segment_reassembler.sv =====
// ----------------------------------------------------------------------------
// can_tp_segment_reassembler
// Receive reassembly of segmented CAN transfers into a byte buffer, with
// start, end, single, first and consecutive frame handling.
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  req_     in         req_valid/req_ready   one received frame
//  rsp_     out        rsp_valid/rsp_ready   status and message chunks
//  csr_     in         csr_wr_en             frame identifier registers
//
// A frame answered at once (status, start, end, single frame) sets rsp_valid
// in the decode state, registered, once the result register is free. A first
// frame writes its six bytes and a consecutive frame up to seven, one buffer
// write a cycle. A completing consecutive frame then reads the sequence word
// back (S_SEQ_HI, S_SEQ_LO, S_SEQ_CAP) and reads each chunk with one buffer
// read a cycle, loads it into the result and waits for its handshake.
// Synchronous reset clears the transfer state and loads the identifier
// registers with their defaults; the buffer holds undefined data until
// written and is not cleared.
// With rsp_ready low the result holds; the next request is taken while the
// final result of a frame still waits.
// ----------------------------------------------------------------------------
module can_tp_segment_reassembler #(
   parameter int BUFFER_BYTES = ctsr_pkg::BUFFER_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_is_standard_id,
   input  logic                           req_is_data_frame,
   input  logic [ctsr_pkg::ID_W-1:0]      req_frame_id,
   input  logic [3:0]                     req_length_code,
   input  logic [7:0]                     req_data_byte0,
   input  logic [7:0]                     req_data_byte1,
   input  logic [7:0]                     req_data_byte2,
   input  logic [7:0]                     req_data_byte3,
   input  logic [7:0]                     req_data_byte4,
   input  logic [7:0]                     req_data_byte5,
   input  logic [7:0]                     req_data_byte6,
   input  logic [7:0]                     req_data_byte7,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_result_code,
   output logic                           rsp_message_valid,
   output logic [1:0]                     rsp_message_kind,
   output logic [31:0]                    rsp_header_word,
   output logic [15:0]                    rsp_sequence_res,
   output logic [8:0]                     rsp_payload_length,
   output logic [63:0]                    rsp_payload_chunk,
   output logic                           rsp_last,
   input  logic                           csr_wr_en,
   input  logic [ctsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctsr_pkg::ID_W-1:0]      csr_wr_data
);
   import ctsr_pkg::*;

   localparam int ADDR_W = $clog2(BUFFER_BYTES);

   ids_type     ids_ff, ids_in;
   frm_type     req_frame;
   frm_type     frm;
   st_type      st;
   dec_type     dec;
   item_type    rsp_item;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   // Identifier registers
   always_comb begin
      ids_in = ids_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_START_ID: ids_in.start_fid = csr_wr_data;
            CSR_END_ID:   ids_in.end_id    = csr_wr_data;
            CSR_DATA_ID:  ids_in.data_id   = csr_wr_data;
            default:      ids_in           = ids_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ids_ff.start_fid <= START_ID_RST;
         ids_ff.end_id    <= END_ID_RST;
         ids_ff.data_id   <= DATA_ID_RST;
      end else begin
         ids_ff <= ids_in;
      end
   end

   // Pack the request
   assign req_frame.is_standard_id = req_is_standard_id;
   assign req_frame.is_data_frame  = req_is_data_frame;
   assign req_frame.frame_id       = req_frame_id;
   assign req_frame.length_code    = req_length_code;
   assign req_frame.data           = {req_data_byte7, req_data_byte6, req_data_byte5,
                                      req_data_byte4, req_data_byte3, req_data_byte2,
                                      req_data_byte1, req_data_byte0};

   ctsr_decode #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_decode (
      .frm (frm),
      .st  (st),
      .ids (ids_ff),
      .dec (dec)
   );

   ctsr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_BYTES)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   ctsr_seq #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_frame   (req_frame),
      .frm         (frm),
      .st          (st),
      .dec         (dec),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .rsp_last    (rsp_last)
   );

   // Unpack the result
   assign rsp_result_code    = rsp_item.code;
   assign rsp_message_valid  = rsp_item.valid;
   assign rsp_message_kind   = rsp_item.kind;
   assign rsp_header_word    = rsp_item.header;
   assign rsp_sequence_res   = rsp_item.seq;
   assign rsp_payload_length = rsp_item.plen;
   assign rsp_payload_chunk  = rsp_item.chunk;

endmodule

// ===== hw/rtl/ctsr_checker.sv =====
// ----------------------------------------------------------------------------
// ctsr_checker
// Port-level checks on the result channel of the segment reassembler.
// ----------------------------------------------------------------------------
module ctsr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_result_code,
   input logic        rsp_message_valid,
   input logic [1:0]  rsp_message_kind,
   input logic [31:0] rsp_header_word,
   input logic [15:0] rsp_sequence_res,
   input logic [8:0]  rsp_payload_length,
   input logic [63:0] rsp_payload_chunk,
   input logic        rsp_last
);
   import ctsr_pkg::*;

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload_chunk) &&
      $stable(rsp_last) && $stable(rsp_result_code))
      else $error("result changed while stalled");

   // A status-only result is a single item with empty fields
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_message_valid |-> rsp_last && (rsp_payload_chunk == 64'd0) &&
      (rsp_header_word == 32'd0) && (rsp_payload_length == 9'd0))
      else $error("status result carries message fields");

   // Delivered messages always report ok
   a_msg_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_valid |-> (rsp_result_code == RC_OK))
      else $error("message delivered with error code");

   // Start and end messages are one item without data fields
   a_hdr_msg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_valid && (rsp_message_kind != KIND_DATA) |->
      rsp_last && (rsp_sequence_res == 16'd0) && (rsp_payload_chunk == 64'd0))
      else $error("header message malformed");

   // Take a new request only once the current frame is down to its final item
   a_one_frame: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |-> !rsp_valid || rsp_last)
      else $error("request accepted while chunks remain");

endmodule

bind can_tp_segment_reassembler ctsr_checker u_checker (.*);

// ===== verif/can_tp_segment_reassembler_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_tp_segment_reassembler_test
// Drives received CAN frames into the reassembler and checks every answer
// against an in-bench reassembly predictor. The run covers frame format
// checks, start and end frames, single, first and consecutive frames, and
// shared and extreme identifier settings. It then sends random transfers
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module can_tp_segment_reassembler_test;
   import ctsr_pkg::*;

   localparam int BUF_BYTES = 512;

   typedef struct packed {
      logic [2:0]  code;
      logic        valid;
      logic [1:0]  kind;
      logic [31:0] header;
      logic [15:0] seq;
      logic [8:0]  plen;
      logic [63:0] chunk;
      logic        last;
   } answer_type;

   logic            clock;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic            req_is_standard_id = 1'b0;
   logic            req_is_data_frame = 1'b0;
   logic [ID_W-1:0] req_frame_id = '0;
   logic [3:0]      req_length_code = '0;
   logic [7:0]      req_data_byte0 = '0;
   logic [7:0]      req_data_byte1 = '0;
   logic [7:0]      req_data_byte2 = '0;
   logic [7:0]      req_data_byte3 = '0;
   logic [7:0]      req_data_byte4 = '0;
   logic [7:0]      req_data_byte5 = '0;
   logic [7:0]      req_data_byte6 = '0;
   logic [7:0]      req_data_byte7 = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [2:0]      rsp_result_code;
   logic            rsp_message_valid;
   logic [1:0]      rsp_message_kind;
   logic [31:0]     rsp_header_word;
   logic [15:0]     rsp_sequence_res;
   logic [8:0]      rsp_payload_length;
   logic [63:0]     rsp_payload_chunk;
   logic            rsp_last;
   logic            csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ID_W-1:0] csr_wr_data = '0;

   // Predictor state and identifier copies
   logic [7:0]      rx_buffer [BUF_BYTES];
   logic [7:0]      msg_bytes [BUF_BYTES];
   bit              rx_active = 1'b0;
   logic [3:0]      rx_next_sn = '0;
   int              rx_total = 0;
   int              rx_copied = 0;
   logic [ID_W-1:0] cfg_start_fid = START_ID_RST;
   logic [ID_W-1:0] cfg_end_id = END_ID_RST;
   logic [ID_W-1:0] cfg_data_id = DATA_ID_RST;

   answer_type      answer_q [$];
   answer_type      head_answer;
   int              mismatches = 0;
   int              frames_sent = 0;
   bit              pace_off = 1'b0;

   can_tp_segment_reassembler dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_is_standard_id (req_is_standard_id),
      .req_is_data_frame  (req_is_data_frame),
      .req_frame_id       (req_frame_id),
      .req_length_code    (req_length_code),
      .req_data_byte0     (req_data_byte0),
      .req_data_byte1     (req_data_byte1),
      .req_data_byte2     (req_data_byte2),
      .req_data_byte3     (req_data_byte3),
      .req_data_byte4     (req_data_byte4),
      .req_data_byte5     (req_data_byte5),
      .req_data_byte6     (req_data_byte6),
      .req_data_byte7     (req_data_byte7),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_result_code    (rsp_result_code),
      .rsp_message_valid  (rsp_message_valid),
      .rsp_message_kind   (rsp_message_kind),
      .rsp_header_word    (rsp_header_word),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_chunk  (rsp_payload_chunk),
      .rsp_last           (rsp_last),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Reassembly predictor
   // ------------------------------------------------------------------------
   function automatic void push_answer(logic [2:0] code, logic valid, logic [1:0] kind,
                                       logic [31:0] header, logic [15:0] seq,
                                       logic [8:0] plen, logic [63:0] chunk, logic last);
      answer_type a;
      a.code   = code;
      a.valid  = valid;
      a.kind   = kind;
      a.header = header;
      a.seq    = seq;
      a.plen   = plen;
      a.chunk  = chunk;
      a.last   = last;
      answer_q.push_back(a);
   endfunction

   // Split msg_bytes into 8-byte chunks, earliest byte in the low bits
   function automatic void push_message(logic [15:0] seq, int plen);
      int          n;
      logic [63:0] chunk;
      n = (plen + 7) / 8;
      if (n == 0) n = 1;
      for (int k = 0; k < n; k++) begin
         chunk = '0;
         for (int b = 0; b < 8; b++) begin
            if (k * 8 + b < plen) chunk[8*b +: 8] = msg_bytes[k * 8 + b];
         end
         push_answer(RC_OK, 1'b1, KIND_DATA, '0, seq, 9'(plen), chunk, k == n - 1);
      end
   endfunction

   function automatic void drop_transfer();
      rx_active = 1'b0;
      rx_copied = 0;
   endfunction

   function automatic void reassemble_frame(frm_type f);
      logic [7:0] d [8];
      int         dlc;
      int         len;
      int         need;
      bit         is_start;
      dlc = f.length_code;
      for (int i = 0; i < 8; i++) d[i] = f.data[i];

      if (!f.is_standard_id || !f.is_data_frame || dlc == 0 || dlc > MAX_DLC) begin
         push_answer(RC_MALFORMED, 0, 0, 0, 0, 0, 0, 1);
      end else if (f.frame_id == cfg_start_fid || f.frame_id == cfg_end_id) begin
         // Start wins over end when both identifiers match
         is_start = (f.frame_id == cfg_start_fid);
         if (dlc < MIN_HDR_DLC || d[0] != (is_start ? START_MARK : END_MARK)) begin
            push_answer(RC_MALFORMED, 0, 0, 0, 0, 0, 0, 1);
         end else begin
            drop_transfer();
            push_answer(RC_OK, 1'b1, is_start ? KIND_START : KIND_END,
                        {d[1], d[2], d[3], d[4]}, 0, 0, 0, 1);
         end
      end else if (f.frame_id != cfg_data_id) begin
         push_answer(RC_MALFORMED, 0, 0, 0, 0, 0, 0, 1);
      end else if (d[0][7:4] == PCI_SINGLE) begin
         len = d[0][3:0];
         if (len < 3 || len > 7 || dlc < len + 1) begin
            push_answer(RC_MALFORMED, 0, 0, 0, 0, 0, 0, 1);
         end else begin
            rx_total = len;
            drop_transfer();
            for (int i = 0; i < len - 2; i++) msg_bytes[i] = d[3 + i];
            push_message({d[1], d[2]}, len - 2);
         end
      end else if (d[0][7:4] == PCI_FIRST) begin
         // A first frame always aborts the running transfer
         drop_transfer();
         len = {d[0][3:0], d[1]};
         if (dlc != 8) begin
            push_answer(RC_MALFORMED, 0, 0, 0, 0, 0, 0, 1);
         end else if (len > BUF_BYTES || len <= 6) begin
            rx_total = 0;
            push_answer(RC_BAD_LENGTH, 0, 0, 0, 0, 0, 0, 1);
         end else begin
            rx_total = len;
            for (int i = 0; i < 6; i++) rx_buffer[i] = d[i + 2];
            rx_copied  = 6;
            rx_active  = 1'b1;
            rx_next_sn = 4'd1;
            push_answer(RC_OK, 0, 0, 0, 0, 0, 0, 1);
         end
      end else if (d[0][7:4] == PCI_CONSEC) begin
         need = (rx_total > rx_copied) ? rx_total - rx_copied : 0;
         if (need > 7) need = 7;
         if (!rx_active) begin
            push_answer(RC_NOT_RECEIVING, 0, 0, 0, 0, 0, 0, 1);
         end else if (dlc < 2 || dlc - 1 < need) begin
            drop_transfer();
            push_answer(RC_MALFORMED, 0, 0, 0, 0, 0, 0, 1);
         end else if (d[0][3:0] != rx_next_sn) begin
            drop_transfer();
            push_answer(RC_SEQ_ERR, 0, 0, 0, 0, 0, 0, 1);
         end else begin
            rx_next_sn = rx_next_sn + 4'd1;
            for (int i = 0; i < 7; i++) begin
               if (rx_copied < rx_total && rx_copied < BUF_BYTES) begin
                  rx_buffer[rx_copied] = d[i + 1];
                  rx_copied++;
               end
            end
            if (rx_copied >= rx_total) begin
               for (int i = 0; i < rx_total - 2; i++) msg_bytes[i] = rx_buffer[i + 2];
               drop_transfer();
               push_message({rx_buffer[0], rx_buffer[1]}, rx_total - 2);
            end else begin
               push_answer(RC_PENDING, 0, 0, 0, 0, 0, 0, 1);
            end
         end
      end else begin
         push_answer(RC_PENDING, 0, 0, 0, 0, 0, 0, 1);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Answer checking
   // ------------------------------------------------------------------------
   function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (answer_q.size() == 0) begin
            $display("%0t: answer expected none, got code %0d chunk %0h", $time,
                     rsp_result_code, rsp_payload_chunk);
            mismatches++;
         end else begin
            head_answer = answer_q.pop_front();
            check_field("result_code", head_answer.code, rsp_result_code);
            check_field("message_valid", head_answer.valid, rsp_message_valid);
            check_field("message_kind", head_answer.kind, rsp_message_kind);
            check_field("header_word", head_answer.header, rsp_header_word);
            check_field("sequence_res", head_answer.seq, rsp_sequence_res);
            check_field("payload_length", head_answer.plen, rsp_payload_length);
            check_field("payload_chunk", head_answer.chunk, rsp_payload_chunk);
            check_field("last", head_answer.last, rsp_last);
         end
      end
   end

   // Stall the answer side: mostly short holds, a few long, some open stretches
   initial begin
      @(posedge clock);
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
         if (!pace_off && $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b0;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(15, 60)) @(posedge clock);
            else repeat ($urandom_range(1, 3)) @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Frame builders and drivers
   // ------------------------------------------------------------------------
   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic frm_type make_frame(logic [ID_W-1:0] id, logic [3:0] dlc,
                                          logic [7:0] b0);
      frm_type f;
      f.is_standard_id = 1'b1;
      f.is_data_frame  = 1'b1;
      f.frame_id       = id;
      f.length_code    = dlc;
      f.data           = rand64();
      f.data[0]        = b0;
      return f;
   endfunction

   function automatic frm_type first_frame(int total);
      frm_type f;
      f = make_frame(cfg_data_id, 4'd8, {PCI_FIRST, 4'(total >> 8)});
      f.data[1] = 8'(total);
      return f;
   endfunction

   function automatic frm_type single_frame();
      frm_type    f;
      logic [3:0] len;
      len = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(3, 7)) : 4'($urandom);
      f = make_frame(cfg_data_id, 4'($urandom_range(1, 8)), {PCI_SINGLE, len});
      if (len >= 3 && len <= 7 && $urandom_range(0, 4) != 0)
         f.length_code = 4'($urandom_range(len + 1, 8));
      return f;
   endfunction

   function automatic frm_type header_frame();
      frm_type f;
      bit      is_start;
      is_start = $urandom_range(0, 1);
      f = make_frame(is_start ? cfg_start_fid : cfg_end_id, 4'($urandom_range(5, 8)),
                     is_start ? START_MARK : END_MARK);
      if ($urandom_range(0, 6) == 0) f.data[0] = 8'($urandom);
      if ($urandom_range(0, 6) == 0) f.length_code = 4'($urandom_range(1, 4));
      return f;
   endfunction

   function automatic frm_type noise_frame();
      frm_type f;
      f.is_standard_id = ($urandom_range(0, 4) != 0);
      f.is_data_frame  = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 5))
         0: f.frame_id = cfg_start_fid;
         1: f.frame_id = cfg_end_id;
         2, 3: f.frame_id = cfg_data_id;
         default: f.frame_id = 11'($urandom);
      endcase
      f.length_code = 4'($urandom);
      f.data        = rand64();
      return f;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (pace_off || r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request, hold it until taken, then predict its answers
   task automatic send_frame(input frm_type f);
      int gap;
      req_valid          <= 1'b1;
      req_is_standard_id <= f.is_standard_id;
      req_is_data_frame  <= f.is_data_frame;
      req_frame_id       <= f.frame_id;
      req_length_code    <= f.length_code;
      req_data_byte0     <= f.data[0];
      req_data_byte1     <= f.data[1];
      req_data_byte2     <= f.data[2];
      req_data_byte3     <= f.data[3];
      req_data_byte4     <= f.data[4];
      req_data_byte5     <= f.data[5];
      req_data_byte6     <= f.data[6];
      req_data_byte7     <= f.data[7];
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      reassemble_frame(f);
      frames_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off requests until every answer is in and the block has settled
   task automatic wait_for_answers();
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_ids(input logic [ID_W-1:0] s, e, d);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_START_ID;
      csr_wr_data <= s;
      @(posedge clock);
      csr_index   <= CSR_END_ID;
      csr_wr_data <= e;
      @(posedge clock);
      csr_index   <= CSR_DATA_ID;
      csr_wr_data <= d;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      cfg_start_fid = s;
      cfg_end_id    = e;
      cfg_data_id   = d;
      @(posedge clock);
   endtask

   // Send a first frame and its consecutive frames; breaks may cut it short
   task automatic run_transfer(input int total, input bit allow_breaks);
      frm_type    f;
      int         left;
      int         n;
      int         r;
      logic [3:0] sn;
      send_frame(first_frame(total));
      left = total - 6;
      sn   = 4'd1;
      while (left > 0) begin
         n = (left > 7) ? 7 : left;
         r = allow_breaks ? $urandom_range(0, 99) : 99;
         if (r < 3) begin
            send_frame(noise_frame());
         end else if (r < 5) begin
            case ($urandom_range(0, 3))
               0: f = make_frame(cfg_data_id, 4'd8, {PCI_CONSEC, sn + 4'($urandom_range(1, 15))});
               1: f = make_frame(cfg_data_id, 4'($urandom_range(1, n)), {PCI_CONSEC, sn});
               2: f = header_frame();
               default: f = single_frame();
            endcase
            send_frame(f);
            return;
         end
         send_frame(make_frame(cfg_data_id, 4'($urandom_range(n + 1, 8)), {PCI_CONSEC, sn}));
         left = left - n;
         sn   = sn + 4'd1;
      end
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return $urandom_range(7, 30);
      if (r < 92) return $urandom_range(31, 120);
      return $urandom_range(121, BUF_BYTES);
   endfunction

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Format, identifier, marker and control nibble checks at reset settings
   task automatic test_frame_checks();
      frm_type f;
      f = make_frame(cfg_start_fid, 4'd5, START_MARK);
      f.is_standard_id = 1'b0;
      send_frame(f);
      f = make_frame(cfg_end_id, 4'd8, END_MARK);
      f.is_data_frame = 1'b0;
      send_frame(f);
      send_frame(make_frame(cfg_data_id, 4'd0, 8'h03));
      send_frame(make_frame(cfg_data_id, 4'd9, 8'h03));
      send_frame(make_frame(cfg_data_id, 4'd15, 8'h03));
      send_frame(make_frame(11'h7FF, 4'd8, 8'h03));
      send_frame(make_frame(cfg_start_fid, 4'd5, START_MARK));
      send_frame(make_frame(cfg_start_fid, 4'd4, START_MARK));
      send_frame(make_frame(cfg_start_fid, 4'd8, 8'hEF));
      f = make_frame(cfg_end_id, 4'd8, END_MARK);
      f.data = '1;
      send_frame(f);
      send_frame(make_frame(cfg_end_id, 4'd6, START_MARK));
      send_frame(make_frame(cfg_data_id, 4'd4, {PCI_SINGLE, 4'd3}));
      send_frame(make_frame(cfg_data_id, 4'd8, {PCI_SINGLE, 4'd7}));
      send_frame(make_frame(cfg_data_id, 4'd8, {PCI_SINGLE, 4'd2}));
      send_frame(make_frame(cfg_data_id, 4'd8, {PCI_SINGLE, 4'd8}));
      send_frame(make_frame(cfg_data_id, 4'd5, {PCI_SINGLE, 4'd5}));
      f = first_frame(100);
      f.length_code = 4'd7;
      send_frame(f);
      send_frame(first_frame(6));
      send_frame(first_frame(BUF_BYTES + 1));
      send_frame(first_frame(12'hFFF));
      send_frame(make_frame(cfg_data_id, 4'd8, {PCI_CONSEC, 4'd1}));
      send_frame(make_frame(cfg_data_id, 4'd8, 8'h30));
      send_frame(make_frame(cfg_data_id, 4'd8, 8'hF0));
      wait_for_answers();
   endtask

   // Sequence numbers, short frames, aborts and restarts of a transfer
   task automatic test_transfer_rules();
      run_transfer(7, 1'b0);
      send_frame(first_frame(20));
      send_frame(make_frame(cfg_data_id, 4'd8, {PCI_CONSEC, 4'd2}));
      send_frame(first_frame(20));
      send_frame(make_frame(cfg_data_id, 4'd3, {PCI_CONSEC, 4'd1}));
      run_transfer(20, 1'b0);
      run_transfer(13, 1'b0);
      send_frame(first_frame(100));
      send_frame(make_frame(cfg_data_id, 4'd8, {PCI_CONSEC, 4'd1}));
      send_frame(make_frame(cfg_start_fid, 4'd8, START_MARK));
      send_frame(make_frame(cfg_data_id, 4'd8, {PCI_CONSEC, 4'd2}));
      send_frame(first_frame(30));
      run_transfer(9, 1'b0);
      wait_for_answers();
   endtask

   // Shared identifiers: start is decoded before end, end before data
   task automatic test_shared_ids();
      write_ids(11'd300, 11'd300, 11'd300);
      send_frame(make_frame(11'd300, 4'd5, START_MARK));
      send_frame(make_frame(11'd300, 4'd8, END_MARK));
      send_frame(first_frame(20));
      wait_for_answers();
      write_ids(11'd5, 11'd9, 11'd9);
      send_frame(make_frame(11'd9, 4'd8, END_MARK));
      send_frame(make_frame(11'd9, 4'd8, {PCI_SINGLE, 4'd3}));
      send_frame(make_frame(11'd5, 4'd7, START_MARK));
      wait_for_answers();
   endtask

   // Largest buffer: sequence number wraps and the most chunks per frame
   task automatic test_long_transfer();
      write_ids(START_ID_RST, END_ID_RST, DATA_ID_RST);
      run_transfer(BUF_BYTES, 1'b0);
      wait_for_answers();
   endtask

   task automatic test_random_traffic(input logic [ID_W-1:0] s, e, d,
                                      input int frames, input bit quiet);
      int stop_at;
      int r;
      write_ids(s, e, d);
      pace_off = quiet;
      stop_at  = frames_sent + frames;
      while (frames_sent < stop_at) begin
         r = $urandom_range(0, 99);
         if (r < 50) run_transfer(pick_length(), 1'b1);
         else if (r < 65) send_frame(single_frame());
         else if (r < 75) send_frame(header_frame());
         else send_frame(noise_frame());
      end
      wait_for_answers();
      pace_off = 1'b0;
   endtask

   initial begin
      logic [ID_W-1:0] id_a;
      logic [ID_W-1:0] id_b;
      logic [ID_W-1:0] id_c;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_frame_checks();
      test_transfer_rules();
      test_shared_ids();
      test_long_transfer();
      test_random_traffic(START_ID_RST, END_ID_RST, DATA_ID_RST, 6, 1'b0);
      id_a = 11'($urandom_range(0, 2047));
      id_b = id_a + 11'($urandom_range(1, 1000));
      id_c = id_b + 11'($urandom_range(1, 1000));
      test_random_traffic(id_a, id_b, id_c, 6, 1'b0);
      test_random_traffic(11'd0, 11'd1, 11'd2047, 5, 1'b1);
      test_random_traffic(11'd2047, 11'd2046, 11'd0, 5, 1'b0);
      repeat (40) @(posedge clock);
      if (mismatches == 0) $display("can_tp_segment_reassembler verification clean");
      else $display("can_tp_segment_reassembler verification failed");
      $finish;
   end

   // Stop a hung run
   initial begin
      #60_000_000;
      $display("can_tp_segment_reassembler verification failed");
      $finish;
   end

endmodule
